[sv/bhq_pkg.sv]
// Shared types and constants for the binned histogram with quantile.
`default_nettype none
package bhq_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUANT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_BELOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ABOVE = 3'd4;

  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned THR_W   = 57;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] sample;
    logic [16:0]        fraction;
    logic [7:0]         bin_select;
  } in_t;

  typedef struct packed {
    logic [8:0]         bin_index;
    logic [31:0]        bin_count;
    logic signed [47:0] bin_centre;
    logic               sample_counted;
    logic               not_reached;
    logic [39:0]        total_count;
  } out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic        hit;
    logic [8:0]  idx;
    logic [16:0] fraction;
  } cmd_t;

  // Effective configuration: width never zero, bins clipped to the store.
  typedef struct packed {
    logic signed [31:0] start;
    logic [30:0]        width;
    logic [8:0]         nbins;
    logic               clamp_below;
    logic               clamp_above;
  } cfg_t;

endpackage
`default_nettype wire

[sv/binned_histogram_with_quantile.sv]
// Top level: configuration registers, front end, request queue and back end.
// Sample path, accept to result valid: range check, 9-step restoring bin divider with
//   one quotient bit per cycle, queue, count, centre; clamped and dropped samples skip
//   the divider. A quantile walks the bins in order from bin zero.
// The front takes no new request while it works on a sample; the back handles one
//   request at a time. Reset: asynchronous, active low; counts read zero at once.
`default_nettype none
module binned_histogram_with_quantile #(
  parameter int unsigned BINS       = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bhq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [31:0]                      cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire bhq_pkg::in_t                     in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output bhq_pkg::out_t                         out_o
);

  localparam int unsigned XW = (BINS > 512) ? $clog2(BINS) + 1 : 10;

  logic signed [31:0] start_q;
  logic [30:0]        width_q;
  logic [8:0]         bins_q;
  logic               clb_q, cla_q;
  bhq_pkg::cfg_t      cfg;
  logic               push, full, pop, empty;
  bhq_pkg::cmd_t      push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      width_q <= 31'd65536;
      bins_q  <= 9'd256;
      clb_q   <= 1'b0;
      cla_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bhq_pkg::CFG_RANGE_START: start_q <= cfg_wdata_i;
        bhq_pkg::CFG_BIN_WIDTH:   width_q <= cfg_wdata_i[30:0];
        bhq_pkg::CFG_BINS_IN_USE: bins_q  <= cfg_wdata_i[8:0];
        bhq_pkg::CFG_CLAMP_BELOW: clb_q   <= cfg_wdata_i[0];
        bhq_pkg::CFG_CLAMP_ABOVE: cla_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.start       = start_q;
    cfg.width       = (width_q == '0) ? 31'd1 : width_q;
    cfg.clamp_below = clb_q;
    cfg.clamp_above = cla_q;
    if (bins_q == '0) begin
      cfg.nbins = 9'd1;
    end else if (XW'(bins_q) > XW'(BINS)) begin
      cfg.nbins = 9'(BINS);
    end else begin
      cfg.nbins = bins_q;
    end
  end

  bhq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  bhq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  bhq_back #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

[sv/bhq_front.sv]
// Front end: accepts requests and works out the bin of each sample.
`default_nettype none
module bhq_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire bhq_pkg::cfg_t cfg_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire bhq_pkg::in_t in_i,
  output logic              push_o,
  output bhq_pkg::cmd_t     push_data_o,
  input  wire logic         full_i
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CHK  = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fst_e;

  fst_e          st_q, st_d;
  logic [32:0]   d_q, d_d;
  logic [31:0]   rem_q, rem_d;
  logic [8:0]    quo_q, quo_d;
  logic [3:0]    k_q, k_d;
  bhq_pkg::cmd_t cmd_q, cmd_d;
  logic [39:0]   limit_q;
  logic [39:0]   trial;
  logic          acc;

  assign in_ready_o = (st_q == F_IDLE) && !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign trial      = {9'b0, cfg_i.width} << k_q;

  always_comb begin
    st_d        = st_q;
    d_d         = d_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    k_d         = k_q;
    cmd_d       = cmd_q;
    push_o      = 1'b0;
    push_data_o = cmd_q;
    case (st_q)
      F_IDLE: begin
        if (acc) begin
          cmd_d.op       = in_i.op;
          cmd_d.fraction = in_i.fraction;
          cmd_d.hit      = 1'b1;
          cmd_d.idx      = {1'b0, in_i.bin_select};
          if (in_i.op == bhq_pkg::OP_ADD) begin
            d_d  = {in_i.sample[31], in_i.sample} - {cfg_i.start[31], cfg_i.start};
            st_d = F_CHK;
          end else begin
            push_o      = 1'b1;
            push_data_o = cmd_d;
          end
        end
      end
      F_CHK: begin
        if (d_q[32]) begin
          cmd_d.hit = cfg_i.clamp_below;
          cmd_d.idx = '0;
          st_d      = F_PUSH;
        end else if ({8'b0, d_q[31:0]} >= limit_q) begin
          cmd_d.hit = cfg_i.clamp_above;
          cmd_d.idx = cfg_i.nbins - 9'd1;
          st_d      = F_PUSH;
        end else begin
          rem_d = d_q[31:0];
          quo_d = '0;
          k_d   = 4'd8;
          st_d  = F_DIV;
        end
      end
      F_DIV: begin
        if ({8'b0, rem_q} >= trial) begin
          rem_d       = rem_q - trial[31:0];
          quo_d[k_q]  = 1'b1;
        end
        if (k_q == 4'd0) begin
          st_d = F_PUSH;
        end else begin
          k_d = k_q - 4'd1;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          st_d   = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
    if (st_q == F_DIV && k_q == 4'd0) begin
      cmd_d.idx = quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    k_q     <= k_d;
    cmd_q   <= cmd_d;
    limit_q <= {31'b0, cfg_i.nbins} * {9'b0, cfg_i.width};
  end

endmodule
`default_nettype wire

[sv/bhq_fifo.sv]
// Two-entry request queue between front and back.
`default_nettype none
module bhq_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bhq_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output bhq_pkg::cmd_t      pop_data_o,
  output logic               empty_o
);

  bhq_pkg::cmd_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

[sv/bhq_back.sv]
// Back end: bin store, counting, quantile walk, centre and result register.
`default_nettype none
module bhq_back #(
  parameter int unsigned BINS       = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bhq_pkg::cfg_t cfg_i,
  output logic               pop_o,
  input  wire bhq_pkg::cmd_t pop_data_i,
  input  wire logic          empty_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bhq_pkg::out_t      out_o
);

  localparam int unsigned AW   = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned XW   = (AW > 9) ? AW : 9;
  localparam int unsigned CUMW = COUNT_BITS + AW + 1;
  localparam int unsigned KW   = (CUMW + 16 > bhq_pkg::THR_W) ? CUMW + 16 : bhq_pkg::THR_W;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_DAT  = 7'b0000010,
    B_QM   = 7'b0000100,
    B_QS   = 7'b0001000,
    B_WALK = 7'b0010000,
    B_MUL  = 7'b0100000,
    B_OUT  = 7'b1000000
  } bst_e;

  function automatic logic [AW-1:0] to_addr(input logic [8:0] i);
    logic [XW-1:0] x;
    x = XW'(i);
    return x[AW-1:0];
  endfunction

  logic [COUNT_BITS-1:0] mem_q [BINS];
  logic [COUNT_BITS-1:0] rd_data_q, cur, wdata;
  logic [BINS-1:0]       vld_q;
  logic                  rdv_q, wr_en, clr;
  logic [AW-1:0]         rd_addr, wr_addr;

  bst_e          st_q, st_d;
  bhq_pkg::cmd_t cmd_q, cmd_d;
  logic [8:0]    idx_q, idx_d, pos_q, pos_d;
  logic [31:0]   cnt_q, cnt_d;
  logic          counted_q, counted_d, notr_q, notr_d, zc_q, zc_d;
  logic [39:0]   total_q, total_d, prod_q, prod_d;
  logic [36:0]   pphi_q, pphi_d, pplo_q, pplo_d;
  logic [bhq_pkg::THR_W-1:0] thr_q, thr_d;
  logic [CUMW-1:0] cum_q, cum_d, cum_n;
  logic          ov_q, ov_d, load;
  bhq_pkg::out_t out_q, out_d;

  assign cur         = rdv_q ? rd_data_q : '0;
  assign cum_n       = cum_q + CUMW'(cur);
  assign out_valid_o = ov_q;
  assign out_o       = out_q;
  assign wr_addr     = to_addr(idx_q);

  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    counted_d = counted_q;
    notr_d    = notr_q;
    zc_d      = zc_q;
    total_d   = total_q;
    prod_d    = prod_q;
    pphi_d    = pphi_q;
    pplo_d    = pplo_q;
    thr_d     = thr_q;
    cum_d     = cum_q;
    pop_o     = 1'b0;
    rd_addr   = to_addr(pos_q);
    wr_en     = 1'b0;
    wdata     = cur + COUNT_BITS'(1);
    clr       = 1'b0;
    load      = 1'b0;
    out_d     = out_q;
    case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          cmd_d     = pop_data_i;
          idx_d     = pop_data_i.idx;
          cnt_d     = '0;
          counted_d = 1'b0;
          notr_d    = 1'b0;
          zc_d      = 1'b0;
          rd_addr   = to_addr(pop_data_i.idx);
          case (pop_data_i.op)
            bhq_pkg::OP_ADD: begin
              if (pop_data_i.hit) begin
                st_d = B_DAT;
              end else begin
                idx_d = '0;
                zc_d  = 1'b1;
                st_d  = B_OUT;
              end
            end
            bhq_pkg::OP_QUANT: st_d = B_QM;
            bhq_pkg::OP_READ:  st_d = B_DAT;
            bhq_pkg::OP_CLEAR: begin
              clr     = 1'b1;
              total_d = '0;
              idx_d   = '0;
              zc_d    = 1'b1;
              st_d    = B_OUT;
            end
            default: st_d = B_IDLE;
          endcase
        end
      end
      B_DAT: begin
        if (cmd_q.op == bhq_pkg::OP_ADD) begin
          counted_d = 1'b1;
          if (cur != '1) begin
            wr_en = 1'b1;
            cnt_d = 32'(wdata);
            if (total_q != '1) total_d = total_q + 40'd1;
          end else begin
            cnt_d = 32'(cur);
          end
        end else begin
          cnt_d = (XW'(idx_q) < XW'(BINS)) ? 32'(cur) : 32'd0;
        end
        st_d = B_MUL;
      end
      B_QM: begin
        pphi_d = {20'b0, cmd_q.fraction} * {17'b0, total_q[39:20]};
        pplo_d = {20'b0, cmd_q.fraction} * {17'b0, total_q[19:0]};
        st_d   = B_QS;
      end
      B_QS: begin
        thr_d   = {pphi_q[36:0], 20'b0} + bhq_pkg::THR_W'(pplo_q);
        cum_d   = '0;
        pos_d   = '0;
        rd_addr = '0;
        if (total_q == '0) begin
          idx_d  = cfg_i.nbins;
          cnt_d  = '0;
          notr_d = 1'b1;
          st_d   = B_MUL;
        end else begin
          st_d = B_WALK;
        end
      end
      B_WALK: begin
        if ({KW'(cum_n), 16'b0} >= {16'b0, KW'(thr_q)}) begin
          idx_d = pos_q;
          cnt_d = 32'(cur);
          st_d  = B_MUL;
        end else if (pos_q == cfg_i.nbins - 9'd1) begin
          idx_d  = cfg_i.nbins;
          cnt_d  = '0;
          notr_d = 1'b1;
          st_d   = B_MUL;
        end else begin
          pos_d   = pos_q + 9'd1;
          rd_addr = to_addr(pos_q + 9'd1);
          cum_d   = cum_n;
        end
      end
      B_MUL: begin
        prod_d = {9'b0, cfg_i.width} * {31'b0, idx_q};
        st_d   = B_OUT;
      end
      B_OUT: begin
        if (!ov_q || out_ready_i) begin
          load                 = 1'b1;
          out_d.bin_index      = idx_q;
          out_d.bin_count      = cnt_q;
          out_d.bin_centre     = zc_q ? 48'sd0 :
                                 48'(cfg_i.start) + 48'(prod_q) + 48'(cfg_i.width >> 1);
          out_d.sample_counted = counted_q;
          out_d.not_reached    = notr_q;
          out_d.total_count    = total_q;
          st_d                 = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
    ov_d = load || (ov_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      ov_q    <= 1'b0;
      total_q <= '0;
      vld_q   <= '0;
    end else begin
      st_q    <= st_d;
      ov_q    <= ov_d;
      total_q <= total_d;
      if (clr) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wdata;
    rd_data_q <= mem_q[rd_addr];
    rdv_q     <= vld_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    cnt_q     <= cnt_d;
    counted_q <= counted_d;
    notr_q    <= notr_d;
    zc_q      <= zc_d;
    prod_q    <= prod_d;
    pphi_q    <= pphi_d;
    pplo_q    <= pplo_d;
    thr_q     <= thr_d;
    cum_q     <= cum_d;
    out_q     <= out_d;
  end

endmodule
`default_nettype wire

[sv/bhq_checker.sv]
// Port-level assertions for the histogram, bound to the top level.
`default_nettype none
module bhq_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire bhq_pkg::out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.sample_counted && out_o.not_reached))
    else $error("counted and not reached together");

  a_notr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.not_reached |-> out_o.bin_count == 32'd0)
    else $error("unreached quantile with nonzero count");

  a_counted_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.sample_counted |-> out_o.total_count != 40'd0)
    else $error("counted sample with zero total");

endmodule

bind binned_histogram_with_quantile bhq_checker u_bhq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
`default_nettype wire

[tb/binned_histogram_with_quantile_tb.sv]
// Testbench for the binned histogram with quantile: queued requests, scoreboard check.
`timescale 1ns / 1ps
module binned_histogram_with_quantile_tb;

  localparam int unsigned NBINS = 256;
  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned TOT_MAX = 64'hFF_FFFF_FFFF;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bhq_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  bhq_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  bhq_pkg::out_t out_o;

  binned_histogram_with_quantile DUT (.*);

  initial forever #5 clk_i = ~clk_i;

  // Predictor state
  longint signed   hs_start;
  longint unsigned hs_width;
  longint unsigned hs_nbins;
  bit hs_clamp_lo, hs_clamp_hi;
  longint unsigned hs_bins [NBINS];
  longint unsigned hs_total;

  bhq_pkg::in_t  pending_reqs [$];
  bhq_pkg::out_t expected_results [$];
  int   mismatches = 0;
  longint unsigned cycles = 0;
  int   send_wait = 0, recv_wait = 0;

  function automatic longint unsigned eff_width();
    return (hs_width == 0) ? 1 : hs_width;
  endfunction

  function automatic longint unsigned eff_nbins();
    if (hs_nbins == 0) return 1;
    if (hs_nbins > NBINS) return NBINS;
    return hs_nbins;
  endfunction

  function automatic logic [47:0] centre_at(longint unsigned idx);
    longint unsigned w;
    longint signed c;
    w = eff_width();
    c = hs_start + longint'(w * idx) + longint'(w >> 1);
    return c[47:0];
  endfunction

  function automatic bhq_pkg::out_t predict_histogram(bhq_pkg::in_t req);
    bhq_pkg::out_t r;
    longint signed d;
    longint unsigned idx, n, thr, cum, i;
    bit hit, found;
    r = '0;
    n = eff_nbins();
    case (req.op)
      bhq_pkg::OP_ADD: begin
        d = longint'(req.sample) - hs_start;
        hit = 1;
        idx = 0;
        if (d < 0) begin
          if (!hs_clamp_lo) hit = 0;
        end else begin
          idx = longint'(d) / eff_width();
          if (idx >= n) begin
            if (hs_clamp_hi) idx = n - 1;
            else hit = 0;
          end
        end
        if (hit) begin
          if (hs_bins[idx] < CNT_MAX) begin
            hs_bins[idx]++;
            if (hs_total < TOT_MAX) hs_total++;
          end
          r.bin_index = idx[8:0];
          r.bin_count = hs_bins[idx][31:0];
          r.bin_centre = centre_at(idx);
          r.sample_counted = 1'b1;
        end
      end
      bhq_pkg::OP_QUANT: begin
        thr = longint'(req.fraction) * hs_total;
        cum = 0;
        found = 0;
        i = 0;
        if (hs_total != 0) begin
          for (i = 0; i < n; i++) begin
            cum += hs_bins[i];
            if ((cum << 16) >= thr) begin
              found = 1;
              break;
            end
          end
        end
        if (found) begin
          idx = i;
          r.bin_count = hs_bins[i][31:0];
        end else begin
          idx = n;
          r.not_reached = 1'b1;
        end
        r.bin_index = idx[8:0];
        r.bin_centre = centre_at(idx);
      end
      bhq_pkg::OP_READ: begin
        idx = req.bin_select;
        r.bin_index = idx[8:0];
        r.bin_count = hs_bins[idx][31:0];
        r.bin_centre = centre_at(idx);
      end
      default: begin
        foreach (hs_bins[k]) hs_bins[k] = 0;
        hs_total = 0;
      end
    endcase
    r.total_count = hs_total[39:0];
    return r;
  endfunction

  // Driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(), predict_histogram(in_i));
        void'(pending_reqs.pop_front());
        in_valid_i <= 1'b0;
        send_wait <= $urandom_range(0, 5);
      end else if (!in_valid_i) begin
        if (send_wait > 0) send_wait <= send_wait - 1;
        else if (pending_reqs.size() > 0) begin
          in_i <= pending_reqs[0];
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_o);
        end else begin
          if (out_o !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_results[0], out_o);
          end
          void'(expected_results.pop_front());
        end
        recv_wait = $urandom_range(0, 5);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [bhq_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bhq_pkg::CFG_RANGE_START: hs_start = longint'(signed'(val));
      bhq_pkg::CFG_BIN_WIDTH:   hs_width = 64'(val[30:0]);
      bhq_pkg::CFG_BINS_IN_USE: hs_nbins = 64'(val[8:0]);
      bhq_pkg::CFG_CLAMP_BELOW: hs_clamp_lo = val[0];
      default:                  hs_clamp_hi = val[0];
    endcase
  endtask

  task automatic configure(input logic [31:0] s, input logic [31:0] w, input logic [31:0] n,
                           input bit lo, input bit hi);
    write_reg(bhq_pkg::CFG_RANGE_START, s);
    write_reg(bhq_pkg::CFG_BIN_WIDTH, w);
    write_reg(bhq_pkg::CFG_BINS_IN_USE, n);
    write_reg(bhq_pkg::CFG_CLAMP_BELOW, {31'd0, lo});
    write_reg(bhq_pkg::CFG_CLAMP_ABOVE, {31'd0, hi});
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic void add_req(bhq_pkg::in_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic bhq_pkg::in_t make_req(bhq_pkg::op_e op, logic [31:0] s, logic [16:0] f,
                                            logic [7:0] b);
    bhq_pkg::in_t r;
    r.op = op;
    r.sample = s;
    r.fraction = f;
    r.bin_select = b;
    return r;
  endfunction

  function automatic bhq_pkg::in_t random_req(longint signed lo, longint unsigned span);
    bhq_pkg::in_t r;
    int k;
    r.sample = $urandom();
    r.fraction = 17'($urandom_range(0, 70000));
    r.bin_select = 8'($urandom());
    k = $urandom_range(0, 99);
    if (k < 70) begin
      r.op = bhq_pkg::OP_ADD;
      if (k < 60) r.sample = 32'(lo + longint'($urandom_range(0, 32'(span))));
    end else if (k < 85) r.op = bhq_pkg::OP_QUANT;
    else if (k < 99) r.op = bhq_pkg::OP_READ;
    else r.op = bhq_pkg::OP_CLEAR;
    return r;
  endfunction

  initial begin
    longint unsigned w, n;
    hs_start = 0; hs_width = 65536; hs_nbins = 256;
    hs_clamp_lo = 0; hs_clamp_hi = 0; hs_total = 0;
    foreach (hs_bins[k]) hs_bins[k] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset config, then extremes and special cases
    add_req(make_req(bhq_pkg::OP_QUANT, 0, 17'd32768, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 32'h8000_0000, 0, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 32'h7FFF_FFFF, 0, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 0, 0, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 32'h00FF_FFFF, 0, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 32'h0100_0000, 0, 0));
    add_req(make_req(bhq_pkg::OP_QUANT, 0, 17'd0, 0));
    add_req(make_req(bhq_pkg::OP_QUANT, 0, 17'd65536, 0));
    add_req(make_req(bhq_pkg::OP_QUANT, 0, 17'h1FFFF, 0));
    add_req(make_req(bhq_pkg::OP_READ, 0, 0, 8'd255));
    add_req(make_req(bhq_pkg::OP_READ, 0, 0, 8'd0));
    add_req(make_req(bhq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 17'h1FFFF, 8'hFF));
    add_req(make_req(bhq_pkg::OP_READ, 0, 0, 8'd255));
    drain();

    // Zero width, zero bins, clamps on
    configure(32'hFFFF_0000, 32'h0, 32'h0, 1, 1);
    add_req(make_req(bhq_pkg::OP_ADD, 32'h8000_0000, 0, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 32'h7FFF_FFFF, 0, 0));
    add_req(make_req(bhq_pkg::OP_QUANT, 0, 17'd65536, 0));
    add_req(make_req(bhq_pkg::OP_READ, 0, 0, 8'd200));
    drain();

    // Oversized bin count, max width, most negative start
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h1FF, 0, 1);
    add_req(make_req(bhq_pkg::OP_ADD, 32'h7FFF_FFFF, 0, 0));
    add_req(make_req(bhq_pkg::OP_ADD, 32'h8000_0000, 0, 0));
    add_req(make_req(bhq_pkg::OP_QUANT, 0, 17'd1, 0));
    add_req(make_req(bhq_pkg::OP_READ, 0, 0, 8'd255));
    drain();

    // Random phases over varied settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: w = $urandom_range(1, 16);
        1: w = $urandom_range(1, 70000);
        2: w = $urandom();
        default: w = 65536;
      endcase
      w = w & 64'h7FFF_FFFF;
      n = (ph % 3 == 0) ? $urandom_range(1, 4) : $urandom_range(0, 511);
      configure($urandom(), 32'(w), 32'(n), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      n = eff_nbins();
      for (int i = 0; i < 150; i++) begin
        bhq_pkg::in_t r;
        r = random_req(hs_start - longint'(eff_width()),
                       (n + 2) * eff_width() > 64'hFFFF_FFFF ? 64'hFFFF_FFFF
                                                            : (n + 2) * eff_width());
        add_req(r);
      end
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/bhq_pkg.sv
sv/bhq_front.sv
sv/bhq_fifo.sv
sv/bhq_back.sv
sv/binned_histogram_with_quantile.sv
sv/bhq_checker.sv
tb/binned_histogram_with_quantile_tb.sv
